/* hdl/qri_pkg.sv */
// ----------------------------------------------------------------------------
// qri_pkg
// Shared types, constants and helpers of the quaternion rate integrator.
// ----------------------------------------------------------------------------
package qri_pkg;

    typedef logic signed [31:0] q30_t;
    typedef q30_t [3:0]         quat_t;
    typedef q30_t [2:0]         vec3_t;

    // Sideband that travels with the product pipeline stages
    typedef struct packed {
        logic valid;
        logic sat;
    } ctl_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               sat;
    } sat_t;

    localparam logic [31:0]        TIME_STEP_RESET = 32'd42949673;
    localparam logic signed [63:0] Q30_MAX         = 64'sd2147483647;
    localparam logic signed [63:0] Q30_MIN         = -64'sd2147483648;
    // 3.0 at LSB 2^-56
    localparam logic signed [63:0] THREE_Q56       = 64'sh0300_0000_0000_0000;
    // half LSB for shifts by 27 and by 28
    localparam logic signed [63:0] RND26           = 64'sd67108864;
    localparam logic signed [63:0] RND27           = 64'sd134217728;

    // Clip to signed Q2.30 range and report clipping
    function automatic sat_t sat_q30(input logic signed [63:0] x);
        sat_t r;
        if (x > Q30_MAX) begin
            r.value = Q30_MAX[31:0];
            r.sat   = 1'b1;
        end else if (x < Q30_MIN) begin
            r.value = Q30_MIN[31:0];
            r.sat   = 1'b1;
        end else begin
            r.value = x[31:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

endpackage

/* hdl/quaternion_rate_integrator.sv */
// ----------------------------------------------------------------------------
// quaternion_rate_integrator
// First-order attitude propagation q*p with p = (p0, w*dt/2) and folded
// norm correction in p0, saturated to signed Q2.30.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per sample; s_tdata holds q0..q3 (Q2.30) and
//   rate x, y, z (Q8.24 rad/s). m_ channel: one result per request;
//   m_tdata holds the propagated q0..q3, m_tuser the saturation flag.
//   time_step_we / time_step_wdata load dt (unsigned Q0.32); write it only
//   while no request is in flight.
// Timing:
//   Eight register stages: a request accepted into stage 1 moves through
//   stages 2 to 8 and raises m_tvalid from the stage 8 register. One request
//   can enter every cycle while the receiver does not stall.
// Reset:
//   aresetn low clears all stage valid bits and loads dt = 42949673 (~0.01 s).
// Stall:
//   While m_tvalid is high and m_tready low, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated. Bubbles are not squeezed.
// ----------------------------------------------------------------------------
module quaternion_rate_integrator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         time_step_we,
    input  logic [31:0]  time_step_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // quat_scalar_in, quat_x_in, quat_y_in, quat_z_in, rate_x, rate_y, rate_z
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // quat_scalar_out, quat_x_out, quat_y_out, quat_z_out
    output logic [127:0] m_tdata,
    // saturated
    output logic [0:0]   m_tuser
);
    import qri_pkg::*;

    logic        ce;
    logic [31:0] time_step_reg;

    // stage 1
    quat_t              q_in;
    logic signed [32:0] dt_s;
    logic signed [63:0] prod1_next [3];
    logic signed [63:0] prod1_reg  [3];
    quat_t              q1_reg;
    logic               v1_reg;

    // stage 2
    logic signed [64:0] pr2_next  [3];
    sat_t               ps2_next  [3];
    logic signed [63:0] qq2_next  [4];
    vec3_t              p2_next;
    logic               sat2_next;
    vec3_t              p2_reg;
    logic [58:0]        qsq2_reg  [4];
    quat_t              q2_reg;
    logic               sat2_reg;
    logic               v2_reg;

    // stage 3
    logic signed [63:0] pp3_next  [3];
    logic [60:0]        qsum3_next;
    logic [58:0]        psq3_reg  [3];
    logic [60:0]        qsum3_reg;
    vec3_t              p3_reg;
    quat_t              q3_reg;
    logic               sat3_reg;
    logic               v3_reg;

    // stage 4
    logic [60:0]        sum4_next;
    logic [60:0]        sum4_reg;
    vec3_t              p4_reg;
    quat_t              q4_reg;
    logic               sat4_reg;
    logic               v4_reg;

    // stage 5
    logic signed [63:0] d5_next;
    logic signed [63:0] sh5_next;
    sat_t               p05_next;
    quat_t              p5_reg;
    quat_t              q5_reg;
    logic               sat5_reg;
    logic               v5_reg;

    ctl_t               ctl5;
    ctl_t               ctl_out;
    quat_t              r_out;

    assign ce       = ~m_tvalid | m_tready;
    assign s_tready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= TIME_STEP_RESET;
        end else if (time_step_we) begin
            time_step_reg <= time_step_wdata;
        end
    end

    // Stage 1: rate times dt
    always_comb begin
        dt_s = $signed({1'b0, time_step_reg});
        for (int i = 0; i < 4; i++) begin
            q_in[i] = s_tdata[32*i +: 32];
        end
        for (int i = 0; i < 3; i++) begin
            prod1_next[i] = $signed(s_tdata[128 + 32*i +: 32]) * dt_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            q1_reg <= q_in;
            for (int i = 0; i < 3; i++) begin
                prod1_reg[i] <= prod1_next[i];
            end
        end
    end

    // Stage 2: round increment to Q2.30, square the start quaternion
    always_comb begin
        sat2_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            pr2_next[i] = (prod1_reg[i] + RND26) >>> 27;
            ps2_next[i] = sat_q30(pr2_next[i][63:0]);
            p2_next[i]  = ps2_next[i].value;
            sat2_next   = sat2_next | ps2_next[i].sat;
        end
        for (int i = 0; i < 4; i++) begin
            qq2_next[i] = $signed(q1_reg[i]) * $signed(q1_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p2_reg   <= p2_next;
            q2_reg   <= q1_reg;
            sat2_reg <= sat2_next;
            for (int i = 0; i < 4; i++) begin
                qsq2_reg[i] <= qq2_next[i][62:4];
            end
        end
    end

    // Stage 3: square the increment, sum the quaternion squares
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pp3_next[i] = $signed(p2_reg[i]) * $signed(p2_reg[i]);
        end
        qsum3_next = 61'(qsq2_reg[0]) + 61'(qsq2_reg[1])
                   + 61'(qsq2_reg[2]) + 61'(qsq2_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                psq3_reg[i] <= pp3_next[i][62:4];
            end
            qsum3_reg <= qsum3_next;
            p3_reg    <= p2_reg;
            q3_reg    <= q2_reg;
            sat3_reg  <= sat2_reg;
        end
    end

    // Stage 4: total of the seven squares
    assign sum4_next = qsum3_reg + 61'(psq3_reg[0]) + 61'(psq3_reg[1])
                     + 61'(psq3_reg[2]);

    always_ff @(posedge aclk) begin
        if (ce) begin
            sum4_reg <= sum4_next;
            p4_reg   <= p3_reg;
            q4_reg   <= q3_reg;
            sat4_reg <= sat3_reg;
        end
    end

    // Stage 5: scalar part p0 = (3 - sum) / 2, rounded and clipped
    always_comb begin
        d5_next  = THREE_Q56 - $signed({3'b000, sum4_reg}) + RND26;
        sh5_next = d5_next >>> 27;
        p05_next = sat_q30(sh5_next);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p5_reg   <= {p4_reg, p05_next.value};
            q5_reg   <= q4_reg;
            sat5_reg <= sat4_reg | p05_next.sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign ctl5 = '{valid: v5_reg, sat: sat5_reg};

    qri_quat_product u_product (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .ctl_in  (ctl5),
        .q_in    (q5_reg),
        .p_in    (p5_reg),
        .ctl_out (ctl_out),
        .r_out   (r_out)
    );

    assign m_tvalid   = ctl_out.valid;
    assign m_tuser[0] = ctl_out.sat;
    assign m_tdata    = r_out;

endmodule

/* hdl/qri_quat_product.sv */
// ----------------------------------------------------------------------------
// qri_quat_product
// Three-stage quaternion product q*p: partial products, four-term sums,
// then rounding to Q2.30 with saturation into the output register.
// ----------------------------------------------------------------------------
module qri_quat_product (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  qri_pkg::ctl_t ctl_in,
    input  qri_pkg::quat_t q_in,
    input  qri_pkg::quat_t p_in,
    output qri_pkg::ctl_t ctl_out,
    output qri_pkg::quat_t r_out
);
    import qri_pkg::*;

    logic signed [63:0] full_next [4][4];
    logic signed [61:0] mp_reg    [4][4];
    ctl_t               ctl6_reg;

    logic signed [63:0] acc_next [4];
    logic signed [63:0] acc_reg  [4];
    ctl_t               ctl7_reg;

    logic signed [64:0] rnd_next [4];
    sat_t               fin_next [4];
    quat_t              r_next;
    logic               sat_next;
    quat_t              r_reg;
    ctl_t               ctl8_reg;

    // Stage 6: sixteen products, floor to LSB 2^-58
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                full_next[i][j] = $signed(q_in[i]) * $signed(p_in[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    mp_reg[i][j] <= full_next[i][j][63:2];
                end
            end
        end
    end

    // Stage 7: Hamilton product sums
    always_comb begin
        acc_next[0] = mp_reg[0][0] - mp_reg[1][1] - mp_reg[2][2] - mp_reg[3][3];
        acc_next[1] = mp_reg[0][1] + mp_reg[1][0] + mp_reg[2][3] - mp_reg[3][2];
        acc_next[2] = mp_reg[0][2] + mp_reg[2][0] + mp_reg[3][1] - mp_reg[1][3];
        acc_next[3] = mp_reg[0][3] + mp_reg[3][0] + mp_reg[1][2] - mp_reg[2][1];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                acc_reg[i] <= acc_next[i];
            end
        end
    end

    // Stage 8: round half up to LSB 2^-30, clip
    always_comb begin
        sat_next = ctl7_reg.sat;
        for (int i = 0; i < 4; i++) begin
            rnd_next[i] = (acc_reg[i] + RND27) >>> 28;
            fin_next[i] = sat_q30(rnd_next[i][63:0]);
            r_next[i]   = fin_next[i].value;
            sat_next    = sat_next | fin_next[i].sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            r_reg <= r_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl6_reg <= '0;
            ctl7_reg <= '0;
            ctl8_reg <= '0;
        end else if (ce) begin
            ctl6_reg <= ctl_in;
            ctl7_reg <= ctl6_reg;
            ctl8_reg <= '{valid: ctl7_reg.valid, sat: sat_next};
        end
    end

    assign ctl_out = ctl8_reg;
    assign r_out   = r_reg;

endmodule

/* hdl/qri_checker.sv */
// ----------------------------------------------------------------------------
// qri_checker
// Port-level checks of the quaternion rate integrator, bound to the top.
// ----------------------------------------------------------------------------
module qri_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [0:0]   m_tuser
);
    logic [3:0] run_cnt_reg;

    // count cycles since reset, hold at nine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_cnt_reg <= '0;
        end else if (run_cnt_reg != 4'd9) begin
            run_cnt_reg <= run_cnt_reg + 4'd1;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        run_cnt_reg == 4'd9 && $past(s_tvalid && s_tready, 8)
        && $past(m_tready, 1) && $past(m_tready, 2) && $past(m_tready, 3)
        && $past(m_tready, 4) && $past(m_tready, 5) && $past(m_tready, 6)
        && $past(m_tready, 7) |-> m_tvalid)
        else $error("request did not reach output after eight cycles");

endmodule

bind quaternion_rate_integrator qri_checker u_qri_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
